>>> rtl/core/stcq_pkg.sv
// Shared constants, types and helper functions of the stepper command queue sequencer.
`timescale 1ns / 1ps

package stcq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DIR_W = 2;
	localparam int COUNT_W = 16;
	localparam int DUTY_W = 16;
	localparam int LEVEL_FIELD_W = 4;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	localparam logic [DUTY_W-1:0] DUTY_RESET = 16'h8000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [DIR_W-1:0] DIR_X_LEFT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_X_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_Y_DOWN = 2'd2;
	localparam logic [DIR_W-1:0] DIR_Y_UP = 2'd3;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [LVL_W-1:0] lvl_t;

	typedef struct packed {
		logic [DIR_W-1:0] dir;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_busy;
	} stat_t;

	// Pin levels for a direction code: bit 0 is pin a, bit 1 is pin b.
	function automatic logic [1:0] pins_for(input logic [DIR_W-1:0] dir);
		logic [1:0] pins;
		case (dir)
			DIR_X_LEFT: pins = 2'b11;
			DIR_X_RIGHT: pins = 2'b00;
			DIR_Y_DOWN: pins = 2'b10;
			DIR_Y_UP: pins = 2'b01;
			default: pins = 2'b00;
		endcase
		return pins;
	endfunction

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/stepper_command_queue_sequencer.sv
// Top level of the stepper command queue sequencer.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one word per item: s_tuser is the action (0 enqueue,
// 1 step tick), s_tdata carries the direction and step count of an enqueue.
// An enqueue stores the command in an eight-entry ring or drops it when full.
// A tick starts, advances or completes the head command and drives the pins.
// The master stream returns one result word per item with the accepted flag,
// both direction pin levels, the duty, the done pulse and the queue level.
// The cfg channel writes the drive duty; it is always ready.
// A word is captured by the load step, executed by the execute step once the
// result register is free, and its result then shows on m_tvalid from that register.
// The controller takes no new word until the last one is executed. While a result
// waits, the next word is still accepted; its execution holds until the result
// register is taken.
// Reset clears the ring pointers, the step counter, the drive state and the
// result valid flag and loads the duty with 32768; ring contents are not cleared.
// When the receiver stalls, the result word holds and at most one more word
// is taken in before s_tready drops.

module stepper_command_queue_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] direction, [17:2] count, [23:18] zero
	input  logic [23:0] s_tdata,
	// [0] action
	input  logic        s_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [1] dir_pin_a, [2] dir_pin_b, [18:3] duty_out,
	// [19] command_done, [23:20] queue_level
	output logic [23:0] m_tdata
);

	stcq_pkg::ctl_t  ctl;
	stcq_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	stcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	stcq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken before the first was executed");

	a_done_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[19]))
		else $error("result flags both an enqueue and a completed command");

	a_done_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> m_tdata[18:3] == 16'd0)
		else $error("duty not zero on a completed command");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:20] <= 4'(stcq_pkg::QUEUE_DEPTH))
		else $error("queue level beyond ring depth");
`endif

endmodule

>>> rtl/core/stcq_ctrl.sv
// Controller state machine: takes one input word and schedules its execution.
`timescale 1ns / 1ps

module stcq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  stcq_pkg::stat_t stat,
	output stcq_pkg::ctl_t  ctl
);

	stcq_pkg::state_t state_q;
	stcq_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		s_tready = 1'b0;
		case (state_q)
			stcq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d = stcq_pkg::ST_EXEC;
				end
			end
			stcq_pkg::ST_EXEC: begin
				// Hold the word until the result register can take its result.
				if (!stat.out_busy) begin
					ctl.exec = 1'b1;
					state_d = stcq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stcq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stcq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/stcq_dpath.sv
// Datapath: command ring, drive state, duty register and result register.
`timescale 1ns / 1ps

module stcq_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stcq_pkg::ctl_t                  ctl,
	output stcq_pkg::stat_t                 stat,
	input  logic [stcq_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            cfg_valid,
	input  logic [stcq_pkg::DUTY_W-1:0]     cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [stcq_pkg::M_DATA_W-1:0]   m_tdata
);

	stcq_pkg::cmd_t cmd_store [stcq_pkg::QUEUE_DEPTH];

	logic                          action_q;
	stcq_pkg::cmd_t                in_cmd_q;
	stcq_pkg::ptr_t                head_q;
	stcq_pkg::ptr_t                tail_q;
	stcq_pkg::lvl_t                fill_q;
	logic [stcq_pkg::COUNT_W-1:0]  steps_q;
	logic                          running_q;
	logic [1:0]                    pins_q;
	logic [stcq_pkg::DUTY_W-1:0]   duty_q;
	logic                          out_valid_q;
	logic [stcq_pkg::M_DATA_W-1:0] out_data_q;

	stcq_pkg::cmd_t                head_cmd;
	logic                          full;
	logic                          empty;
	logic                          store_we;
	logic [stcq_pkg::COUNT_W-1:0]  steps_inc;
	logic                          finish;
	stcq_pkg::ptr_t                head_d;
	stcq_pkg::ptr_t                tail_d;
	stcq_pkg::lvl_t                fill_d;
	logic [stcq_pkg::COUNT_W-1:0]  steps_d;
	logic                          running_d;
	logic [1:0]                    pins_d;
	logic                          accepted;
	logic                          done;
	logic [stcq_pkg::DUTY_W-1:0]   duty_res;

	assign head_cmd = cmd_store[head_q];
	assign full = (fill_q == stcq_pkg::LVL_W'(stcq_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign steps_inc = (steps_q == stcq_pkg::COUNT_MAX) ? steps_q
		: steps_q + stcq_pkg::COUNT_W'(1);
	assign finish = (steps_inc >= head_cmd.count);

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		steps_d = steps_q;
		running_d = running_q;
		pins_d = pins_q;
		accepted = 1'b0;
		done = 1'b0;
		store_we = 1'b0;
		if (action_q == stcq_pkg::ACT_ENQUEUE) begin
			if (!full) begin
				store_we = 1'b1;
				tail_d = stcq_pkg::ptr_next(tail_q);
				fill_d = fill_q + stcq_pkg::LVL_W'(1);
				accepted = 1'b1;
			end
		end else if (empty) begin
			running_d = 1'b0;
			steps_d = '0;
		end else begin
			// An idle drive latches the pins from the head command first.
			if (!running_q) begin
				pins_d = stcq_pkg::pins_for(head_cmd.dir);
			end
			if (finish) begin
				head_d = stcq_pkg::ptr_next(head_q);
				fill_d = fill_q - stcq_pkg::LVL_W'(1);
				running_d = 1'b0;
				steps_d = '0;
				done = 1'b1;
			end else begin
				running_d = 1'b1;
				steps_d = steps_inc;
			end
		end
	end

	assign duty_res = running_d ? duty_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			action_q <= s_tuser;
			in_cmd_q.dir <= s_tdata[stcq_pkg::DIR_W-1:0];
			in_cmd_q.count <= s_tdata[stcq_pkg::DIR_W+stcq_pkg::COUNT_W-1:stcq_pkg::DIR_W];
		end
		if (ctl.exec && store_we) begin
			cmd_store[tail_q] <= in_cmd_q;
		end
		if (ctl.exec) begin
			out_data_q <= {stcq_pkg::LEVEL_FIELD_W'(fill_d), done, duty_res,
				pins_d[1], pins_d[0], accepted};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			steps_q <= '0;
			running_q <= 1'b0;
			pins_q <= '0;
			duty_q <= stcq_pkg::DUTY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				duty_q <= cfg_data;
			end
			if (ctl.exec) begin
				head_q <= head_d;
				tail_q <= tail_d;
				fill_q <= fill_d;
				steps_q <= steps_d;
				running_q <= running_d;
				pins_q <= pins_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule
